/* sv/ilist_pkg.sv */
// ----------------------------------------------------------------------------
// ilist_pkg: shared types and constants for the indexed list engine
//
// Holds the request and result payload types, the status and action codes,
// and the command and status structs that join the controller and the
// datapath.
// ----------------------------------------------------------------------------
package ilist_pkg;

    // Default sizing of the slot store.
    localparam int CAPACITY_DEF   = 256;
    localparam int VALUE_BITS_DEF = 32;

    // Fixed field widths of the request and result items.
    localparam int POS_BITS    = 8;
    localparam int DATA_BITS   = 32;
    localparam int STATUS_BITS = 2;
    localparam int LENGTH_BITS = 9;

    // Request actions.
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_DELETE = 1'b1;

    // Result status codes.
    localparam logic [STATUS_BITS-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd2;

    // One request item.
    typedef struct packed {
        logic                        action;
        logic [POS_BITS-1:0]         position;
        logic signed [DATA_BITS-1:0] value;
    } req_t;

    // One result item.
    typedef struct packed {
        logic signed [DATA_BITS-1:0] removed_value;
        logic [STATUS_BITS-1:0]      status;
        logic [LENGTH_BITS-1:0]      length;
    } resp_t;

    // Datapath step that the controller requests in a cycle.
    typedef enum logic [2:0] {
        STEP_NONE,
        STEP_LOAD,
        STEP_CHECK,
        STEP_ALLOC,
        STEP_WALK,
        STEP_LINK,
        STEP_FREE,
        STEP_OUT
    } dp_step_t;

    // Command from the controller to the datapath.
    typedef struct packed {
        dp_step_t step;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_delete;
        logic full;
        logic empty;
        logic ins_simple;
        logic walk_done;
    } dp_status_t;

endpackage

/* sv/ilist_ctrl.sv */
// ----------------------------------------------------------------------------
// ilist_ctrl: request sequencer of the indexed list engine
//
// Accepts one request at a time, steps the datapath through check,
// allocation, link walk, link repair and slot release, and hands the
// result to the output register once the receiver has room.
// ----------------------------------------------------------------------------
module ilist_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    input  ilist_pkg::dp_status_t  status,
    output ilist_pkg::dp_cmd_t     cmd
);
    import ilist_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_CHECK  = 7'b0000010,
        S_ALLOC  = 7'b0000100,
        S_WALK   = 7'b0001000,
        S_LINK   = 7'b0010000,
        S_FREE   = 7'b0100000,
        S_RESULT = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    // Next state, datapath step and output valid.
    always_comb begin
        state_next   = state_reg;
        cmd.step     = STEP_NONE;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.step   = STEP_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                cmd.step = STEP_CHECK;
                if (status.is_delete) begin
                    state_next = status.empty ? S_RESULT : S_WALK;
                end else begin
                    state_next = status.full ? S_RESULT : S_ALLOC;
                end
            end
            S_ALLOC: begin
                cmd.step   = STEP_ALLOC;
                state_next = status.ins_simple ? S_RESULT : S_WALK;
            end
            S_WALK: begin
                cmd.step = STEP_WALK;
                if (status.walk_done) begin
                    state_next = status.is_delete ? S_FREE : S_LINK;
                end
            end
            S_LINK: begin
                cmd.step   = STEP_LINK;
                state_next = S_RESULT;
            end
            S_FREE: begin
                cmd.step   = STEP_FREE;
                state_next = S_RESULT;
            end
            S_RESULT: begin
                // Load the result only once the output register is free.
                if (!m_valid_reg || m_ready) begin
                    cmd.step     = STEP_OUT;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and valid registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

/* sv/ilist_dp.sv */
// ----------------------------------------------------------------------------
// ilist_dp: slot store and link datapath of the indexed list engine
//
// Holds the value, next-link and prev-link memories, the list head, tail,
// free chain head and element count, and performs the step that the
// controller requests in each cycle.
// ----------------------------------------------------------------------------
module ilist_dp #(
    parameter int CAPACITY   = ilist_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = ilist_pkg::VALUE_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ilist_pkg::req_t        s_data,
    input  ilist_pkg::dp_cmd_t     cmd,
    output ilist_pkg::dp_status_t  status,
    output ilist_pkg::resp_t       m_data
);
    import ilist_pkg::*;

    localparam int SW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_BITS) ? CW : POS_BITS;

    // Memories.
    logic [VALUE_BITS-1:0] val_mem  [CAPACITY];
    logic [SW-1:0]         next_mem [CAPACITY];
    logic [SW-1:0]         prev_mem [CAPACITY];

    logic [VALUE_BITS-1:0] val_rd_reg;
    logic [SW-1:0]         next_rd_reg;
    logic [SW-1:0]         prev_rd_reg;

    logic [SW-1:0]         rd_addr;
    logic                  val_we, next_we, prev_we;
    logic [SW-1:0]         val_waddr, next_waddr, prev_waddr;
    logic [VALUE_BITS-1:0] val_wdata;
    logic [SW-1:0]         next_wdata, prev_wdata;

    // List control registers.
    logic [SW-1:0] first_reg, first_next;
    logic [SW-1:0] last_reg, last_next;
    logic [SW-1:0] free_reg, free_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] mark_reg, mark_next;

    // Request and working registers.
    logic                        action_reg, action_next;
    logic [POS_BITS-1:0]         pos_reg, pos_next;
    logic signed [DATA_BITS-1:0] value_reg, value_next;
    logic [SW-1:0]               slot_reg, slot_next;
    logic [SW-1:0]               cur_reg, cur_next;
    logic [SW-1:0]               before_reg, before_next;
    logic [POS_BITS-1:0]         rem_reg, rem_next;
    logic [DATA_BITS-1:0]        removed_reg, removed_next;
    logic [STATUS_BITS-1:0]      code_reg, code_next;
    resp_t                       out_reg, out_next;

    // Derived values.
    logic [CMPW-1:0]   pos_ext, cnt_ext, last_idx, clamped;
    logic              full, empty, pos_ge_cnt, fresh;
    logic [SW-1:0]     free_inc;
    logic [63:0]       wval64, rval64;
    logic [31:0]       cnt32;

    assign pos_ext    = CMPW'(pos_reg);
    assign cnt_ext    = CMPW'(count_reg);
    assign last_idx   = cnt_ext - 1'b1;
    assign clamped    = (pos_ext > last_idx) ? last_idx : pos_ext;
    assign full       = (count_reg == CW'(CAPACITY));
    assign empty      = (count_reg == '0);
    assign pos_ge_cnt = (pos_ext >= cnt_ext);
    // A slot at or above the fill mark was never linked; its free successor
    // is the next slot in order.
    assign fresh      = (CW'(free_reg) >= mark_reg);
    assign free_inc   = (free_reg == SW'(CAPACITY - 1)) ? '0 : free_reg + 1'b1;
    assign wval64     = 64'($unsigned(value_reg));
    assign rval64     = 64'(val_rd_reg);
    assign cnt32      = 32'(count_reg);

    assign status.is_delete  = (action_reg == ACT_DELETE);
    assign status.full       = full;
    assign status.empty      = empty;
    assign status.ins_simple = empty || (pos_reg == '0) || pos_ge_cnt;
    assign status.walk_done  = (rem_reg == '0);

    assign m_data = out_reg;

    // Step decode: memory ports and next register values.
    always_comb begin
        rd_addr      = first_reg;
        val_we       = 1'b0;
        next_we      = 1'b0;
        prev_we      = 1'b0;
        val_waddr    = slot_reg;
        next_waddr   = slot_reg;
        prev_waddr   = slot_reg;
        val_wdata    = wval64[VALUE_BITS-1:0];
        next_wdata   = '0;
        prev_wdata   = '0;
        first_next   = first_reg;
        last_next    = last_reg;
        free_next    = free_reg;
        count_next   = count_reg;
        mark_next    = mark_reg;
        action_next  = action_reg;
        pos_next     = pos_reg;
        value_next   = value_reg;
        slot_next    = slot_reg;
        cur_next     = cur_reg;
        before_next  = before_reg;
        rem_next     = rem_reg;
        removed_next = removed_reg;
        code_next    = code_reg;
        out_next     = out_reg;
        case (cmd.step)
            STEP_LOAD: begin
                action_next  = s_data.action;
                pos_next     = s_data.position;
                value_next   = s_data.value;
                removed_next = '0;
                code_next    = STATUS_DONE;
            end
            STEP_CHECK: begin
                if (action_reg == ACT_INSERT) begin
                    // Fetch the free chain successor of the slot to be taken.
                    rd_addr = free_reg;
                    if (full) begin
                        code_next = STATUS_FULL;
                    end
                end else begin
                    // Start the walk at the head; a position past the end
                    // selects the last element.
                    rd_addr  = first_reg;
                    cur_next = first_reg;
                    rem_next = clamped[POS_BITS-1:0];
                    if (empty) begin
                        code_next = STATUS_EMPTY;
                    end
                end
            end
            STEP_ALLOC: begin
                slot_next  = free_reg;
                free_next  = fresh ? free_inc : next_rd_reg;
                if (fresh) begin
                    mark_next = mark_reg + 1'b1;
                end
                val_we     = 1'b1;
                val_waddr  = free_reg;
                count_next = count_reg + 1'b1;
                if (empty) begin
                    next_we    = 1'b1;
                    next_waddr = free_reg;
                    next_wdata = '0;
                    prev_we    = 1'b1;
                    prev_waddr = free_reg;
                    prev_wdata = '0;
                    first_next = free_reg;
                    last_next  = free_reg;
                end else if (pos_reg == '0) begin
                    next_we    = 1'b1;
                    next_waddr = free_reg;
                    next_wdata = first_reg;
                    prev_we    = 1'b1;
                    prev_waddr = first_reg;
                    prev_wdata = free_reg;
                    first_next = free_reg;
                end else if (pos_ge_cnt) begin
                    prev_we    = 1'b1;
                    prev_waddr = free_reg;
                    prev_wdata = last_reg;
                    next_we    = 1'b1;
                    next_waddr = last_reg;
                    next_wdata = free_reg;
                    last_next  = free_reg;
                end else begin
                    rd_addr  = first_reg;
                    cur_next = first_reg;
                    rem_next = pos_reg;
                end
            end
            STEP_WALK: begin
                // The read registers always hold the entries of cur_reg.
                if (rem_reg != '0) begin
                    rd_addr  = next_rd_reg;
                    cur_next = next_rd_reg;
                    rem_next = rem_reg - 1'b1;
                end else if (action_reg == ACT_INSERT) begin
                    next_we     = 1'b1;
                    next_waddr  = prev_rd_reg;
                    next_wdata  = slot_reg;
                    prev_we     = 1'b1;
                    prev_waddr  = cur_reg;
                    prev_wdata  = slot_reg;
                    before_next = prev_rd_reg;
                end else begin
                    removed_next = rval64[DATA_BITS-1:0];
                    if (count_reg == CW'(1)) begin
                        first_next = '0;
                        last_next  = '0;
                    end else if (cur_reg == first_reg) begin
                        first_next = next_rd_reg;
                    end else if (cur_reg == last_reg) begin
                        last_next = prev_rd_reg;
                    end else begin
                        next_we    = 1'b1;
                        next_waddr = prev_rd_reg;
                        next_wdata = next_rd_reg;
                        prev_we    = 1'b1;
                        prev_waddr = next_rd_reg;
                        prev_wdata = prev_rd_reg;
                    end
                end
            end
            STEP_LINK: begin
                next_we    = 1'b1;
                next_waddr = slot_reg;
                next_wdata = cur_reg;
                prev_we    = 1'b1;
                prev_waddr = slot_reg;
                prev_wdata = before_reg;
            end
            STEP_FREE: begin
                // Push the removed slot onto the free chain.
                next_we    = 1'b1;
                next_waddr = cur_reg;
                next_wdata = free_reg;
                free_next  = cur_reg;
                count_next = count_reg - 1'b1;
            end
            STEP_OUT: begin
                out_next.removed_value = signed'(removed_reg);
                out_next.status        = code_reg;
                out_next.length        = cnt32[LENGTH_BITS-1:0];
            end
            default: begin
            end
        endcase
    end

    // Memory ports with registered reads.
    always_ff @(posedge aclk) begin
        if (val_we) begin
            val_mem[val_waddr] <= val_wdata;
        end
        val_rd_reg <= val_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (next_we) begin
            next_mem[next_waddr] <= next_wdata;
        end
        next_rd_reg <= next_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (prev_we) begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        prev_rd_reg <= prev_mem[rd_addr];
    end

    // List control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= '0;
            last_reg  <= '0;
            free_reg  <= '0;
            count_reg <= '0;
            mark_reg  <= '0;
        end else begin
            first_reg <= first_next;
            last_reg  <= last_next;
            free_reg  <= free_next;
            count_reg <= count_next;
            mark_reg  <= mark_next;
        end
    end

    // Request, working and result payload registers.
    always_ff @(posedge aclk) begin
        action_reg  <= action_next;
        pos_reg     <= pos_next;
        value_reg   <= value_next;
        slot_reg    <= slot_next;
        cur_reg     <= cur_next;
        before_reg  <= before_next;
        rem_reg     <= rem_next;
        removed_reg <= removed_next;
        code_reg    <= code_next;
        out_reg     <= out_next;
    end

endmodule

/* sv/indexed_list_insert_delete_top.sv */
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_top: bounded ordered list engine
//
// Inserts a value at a list position or removes the element at a position,
// keeping the list as a doubly linked chain of slots in on-chip memory.
// ----------------------------------------------------------------------------
// Usage:
// A request transfer on the s_ channel carries the action, the position and
// the value to insert. Exactly one result transfer follows on the m_ channel
// with the removed value, the status and the list length after the request.
// Requests are handled one at a time. An insert inside the list and a delete
// walk P link hops from the head to the position, where P is at most
// CAPACITY - 1; the hop loop does one registered next-link memory read per
// cycle. An insert at the head or at the end and a rejected request skip
// the walk. The engine is ready again in the cycle in which it presents the
// result.
// A new request can be taken while the previous result still waits in the
// output register; if the receiver stalls, the engine holds its next result
// until the register is free and takes no further request until then.
// Reset empties the list and rebuilds the free chain at once through a fill
// mark; no clearing pass is needed.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete_top #(
    parameter int CAPACITY   = ilist_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = ilist_pkg::VALUE_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ilist_pkg::req_t   s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ilist_pkg::resp_t  m_data
);
    import ilist_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Request sequencer.
    ilist_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Slot store and link datapath.
    ilist_dp #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_data  (m_data)
    );

endmodule
